>>> design/hpcq_pkg.sv
// Shared types, constants and header field access functions for the priority classify queue.
package hpcq_pkg;

    localparam int NUM_PRIORITIES_DEF = 16;
    localparam int RING_DEPTH_DEF = 64;
    localparam int MAX_CREDIT_DEF = 32;

    localparam int HANDLE_W = 16;
    localparam int PRIO_W = 4;
    localparam int CREDIT_W = 6;
    localparam int HDR_W = 384;
    localparam int FIFO_DEPTH = 4;

    localparam logic [15:0] ETH_QINQ = 16'h88A8;
    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [3:0] IP_VERSION_OK = 4'd4;
    localparam logic [7:0] IP_PROTO_UDP = 8'd17;
    localparam logic [15:0] PORT_SERVER = 16'd67;
    localparam logic [15:0] PORT_CLIENT = 16'd68;

    localparam logic [0:0] CFG_DHCP_QUEUE = 1'b0;
    localparam logic [0:0] CFG_DEFAULT_QUEUE = 1'b1;

    typedef enum logic [1:0] {
        KIND_FWD  = 2'd0,
        KIND_FULL = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    // One classified command handed from the front to the back.
    typedef struct packed {
        cmd_t                  cmd;
        logic                  bad;
        logic [5:0]            prio;
        logic [HANDLE_W-1:0]   handle;
        logic [CREDIT_W-1:0]   credit;
    } work_t;

    function automatic logic [7:0] hdr_byte(input logic [HDR_W-1:0] hdr, input int k);
        hdr_byte = hdr[(HDR_W - 8 - 8 * k) +: 8];
    endfunction

    function automatic logic [15:0] hdr_half(input logic [HDR_W-1:0] hdr, input int k);
        hdr_half = {hdr_byte(hdr, k), hdr_byte(hdr, k + 1)};
    endfunction

endpackage

>>> design/header_priority_classify_queue_core.sv
// Top level of the header priority classify queue with configuration registers.
// An item passes the front register and the FIFO before the back takes it; a drop result is
// offered from the next cycle, and a dequeue passes the read and emit states per handle.
// Throughput: one enqueue per cycle while the back is idle and no result is held back; each
// handle is read from the handle memory into a register first. rst_n clears all queues and
// control state asynchronously; the DHCP queue resets to 0 and the default queue to 15.
module header_priority_classify_queue_core #(
    parameter int NUM_PRIORITIES = hpcq_pkg::NUM_PRIORITIES_DEF,
    parameter int RING_DEPTH = hpcq_pkg::RING_DEPTH_DEF,
    parameter int MAX_CREDIT = hpcq_pkg::MAX_CREDIT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: packet_handle[15:0], header_word_0..5 [399:16], send_credit[405:400], zero pad
    input  logic [407:0] s_axis_tdata,
    // tuser: command
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_handle[15:0], out_priority[19:16], zero pad
    output logic [23:0]  m_axis_tdata,
    // tuser: result_kind
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [3:0]   cfg_data
);
    import hpcq_pkg::*;

    logic [3:0]  high_reg;
    logic [3:0]  low_reg;
    logic [HDR_W-1:0] hdr;
    logic        fv;
    logic        fr;
    work_t       fd;
    logic        bv;
    logic        br;
    work_t       bd;
    logic [3:0]  oprio;
    logic [15:0] ohandle;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            hdr[HDR_W - 64 * (i + 1) +: 64] = s_axis_tdata[16 + 64 * i +: 64];
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= 4'd0;
            low_reg <= 4'd15;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DHCP_QUEUE:    high_reg <= cfg_data;
                CFG_DEFAULT_QUEUE: low_reg <= cfg_data;
                default:           high_reg <= high_reg;
            endcase
        end
    end

    hpcq_front #(.NUM_PRIORITIES(NUM_PRIORITIES)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .cmd(s_axis_tuser), .handle(s_axis_tdata[15:0]), .hdr(hdr),
        .credit(s_axis_tdata[405:400]),
        .high_prio(high_reg), .low_prio(low_reg),
        .w_valid(fv), .w_ready(fr), .w_data(fd)
    );

    hpcq_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fv), .in_ready(fr), .in_data(fd),
        .out_valid(bv), .out_ready(br), .out_data(bd)
    );

    hpcq_back #(
        .NUM_PRIORITIES(NUM_PRIORITIES), .RING_DEPTH(RING_DEPTH), .MAX_CREDIT(MAX_CREDIT)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .w_valid(bv), .w_ready(br), .w_data(bd),
        .o_valid(m_axis_tvalid), .o_ready(m_axis_tready),
        .o_kind(m_axis_tuser), .o_handle(ohandle), .o_prio(oprio), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, oprio, ohandle};

    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_FWD || m_axis_tuser == KIND_FULL ||
                           m_axis_tuser == KIND_BAD))
        else $error("bad result kind");
    a_bad_prio: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_BAD) |-> (oprio == 4'd0 && m_axis_tlast))
        else $error("unparsable result with nonzero priority");
    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FULL) |-> m_axis_tlast)
        else $error("drop result not marked last");
endmodule

>>> design/hpcq_front.sv
// Front stage: decodes headers, picks a queue index and registers the work item.
module hpcq_front #(
    parameter int NUM_PRIORITIES = hpcq_pkg::NUM_PRIORITIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [hpcq_pkg::HANDLE_W-1:0]     handle,
    input  logic [hpcq_pkg::HDR_W-1:0]        hdr,
    input  logic [hpcq_pkg::CREDIT_W-1:0]     credit,
    input  logic [3:0]                        high_prio,
    input  logic [3:0]                        low_prio,
    output logic                              w_valid,
    input  logic                              w_ready,
    output hpcq_pkg::work_t                   w_data
);
    import hpcq_pkg::*;

    logic   valid_reg;
    work_t  data_reg;
    work_t  cls;

    function automatic logic [5:0] sat_q(input logic [5:0] q);
        sat_q = (int'(q) >= NUM_PRIORITIES) ? 6'(NUM_PRIORITIES - 1) : q;
    endfunction

    function automatic logic [6:0] ip_prio(input logic [HDR_W-1:0] h, input int ip,
                                           input logic [5:0] l2, input logic [5:0] hp);
        logic [7:0] vihl;
        logic [7:0] tos;
        logic [5:0] dscp;
        logic [5:0] p;
        logic [6:0] v;
        logic [15:0] sp;
        logic [15:0] dp;
        logic bad;
        vihl = hdr_byte(h, ip);
        tos = hdr_byte(h, ip + 1);
        dscp = tos[7:2];
        p = l2;
        bad = vihl[7:4] != IP_VERSION_OK;
        v = 7'(NUM_PRIORITIES - 1) - {1'b0, dscp};
        if (dscp != 6'd0)
        begin
            p = v[6] ? 6'd0 : v[5:0];
        end
        sp = hdr_half(h, ip + 20);
        dp = hdr_half(h, ip + 22);
        if (hdr_byte(h, ip + 9) == IP_PROTO_UDP &&
            ((sp == PORT_SERVER && dp == PORT_CLIENT) || (sp == PORT_CLIENT && dp == PORT_SERVER)))
        begin
            p = hp;
        end
        ip_prio = {bad, p};
    endfunction

    always_comb
    begin
        logic [15:0] et;
        logic [15:0] stag;
        logic [15:0] ctag;
        logic [2:0] spcp;
        logic [2:0] cpcp;
        logic [6:0] r;
        et = hdr_half(hdr, 12);
        stag = hdr_half(hdr, 14);
        ctag = hdr_half(hdr, 18);
        spcp = stag[15:13];
        cpcp = ctag[15:13];
        cls.cmd = cmd_t'(cmd);
        cls.handle = handle;
        cls.credit = credit;
        cls.bad = 1'b0;
        cls.prio = 6'd0;
        r = 7'd0;
        if (et == ETH_QINQ)
        begin
            if (hdr_half(hdr, 16) != ETH_VLAN)
            begin
                cls.bad = 1'b1;
            end
            else
            begin
                r = ip_prio(hdr, 22, {3'd0, (spcp != 3'd0) ? spcp : cpcp},
                            sat_q({2'd0, high_prio}));
                cls.bad = r[6];
                cls.prio = sat_q(r[5:0]);
            end
        end
        else if (et == ETH_IPV4)
        begin
            r = ip_prio(hdr, 14, sat_q({2'd0, low_prio}), sat_q({2'd0, high_prio}));
            cls.bad = r[6];
            cls.prio = sat_q(r[5:0]);
        end
        if (cls.bad)
        begin
            cls.prio = 6'd0;
        end
    end

    assign in_ready = !valid_reg || w_ready;
    assign w_valid = valid_reg;
    assign w_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= cls;
        end
    end
endmodule

>>> design/hpcq_fifo.sv
// Short queue of classified work items between the front and the back.
module hpcq_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hpcq_pkg::work_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hpcq_pkg::work_t   out_data
);
    import hpcq_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    work_t        mem_reg [FIFO_DEPTH];
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push;
    logic          pop;

    assign in_ready = cnt_reg != (AW + 1)'(FIFO_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW + 1)'(push) - (AW + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_data;
        end
    end
endmodule

>>> design/hpcq_back.sv
// Back stage: ring storage per queue, enqueue and strict-priority dequeue sequencer.
module hpcq_back #(
    parameter int NUM_PRIORITIES = hpcq_pkg::NUM_PRIORITIES_DEF,
    parameter int RING_DEPTH = hpcq_pkg::RING_DEPTH_DEF,
    parameter int MAX_CREDIT = hpcq_pkg::MAX_CREDIT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            w_valid,
    output logic                            w_ready,
    input  hpcq_pkg::work_t                 w_data,
    output logic                            o_valid,
    input  logic                            o_ready,
    output logic [1:0]                      o_kind,
    output logic [hpcq_pkg::HANDLE_W-1:0]   o_handle,
    output logic [hpcq_pkg::PRIO_W-1:0]     o_prio,
    output logic                            o_last
);
    import hpcq_pkg::*;

    localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int KW = $clog2(MAX_CREDIT + 1);
    localparam int SD = 2 ** (PW + RW);

    logic [HANDLE_W-1:0] store_reg [SD];
    logic [RW-1:0]       wp_reg [NUM_PRIORITIES];
    logic [CW-1:0]       fill_reg [NUM_PRIORITIES];
    logic [NUM_PRIORITIES-1:0] nonempty;

    state_t              state_reg;
    state_t              state_next;
    logic [KW-1:0]       left_reg;
    logic [PW-1:0]       q_reg;
    logic [HANDLE_W-1:0] rdata_reg;
    logic                ov_reg;
    logic [1:0]          ok_reg;
    logic [HANDLE_W-1:0] oh_reg;
    logic [PRIO_W-1:0]   op_reg;
    logic                ol_reg;

    logic                any_ne;
    logic [PW-1:0]       first_q;
    logic                out_free;
    logic                take;
    logic                is_enq;
    logic                enq_full;
    logic [PW-1:0]       wq;
    logic                do_read;
    logic                emit;
    logic [CW-1:0]       rd_base;
    logic [RW-1:0]       rd_idx;
    logic [KW-1:0]       credit_sat;
    logic                last_pkt;

    always_comb
    begin
        for (int i = 0; i < NUM_PRIORITIES; i++)
        begin
            nonempty[i] = fill_reg[i] != '0;
        end
    end

    always_comb
    begin
        any_ne = 1'b0;
        first_q = '0;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                any_ne = 1'b1;
                first_q = PW'(i);
            end
        end
    end

    assign out_free = !ov_reg || o_ready;
    assign wq = w_data.prio[PW-1:0];
    assign is_enq = w_data.cmd == CMD_ENQ;
    assign enq_full = fill_reg[wq] == CW'(RING_DEPTH);
    assign credit_sat = (int'(w_data.credit) > MAX_CREDIT) ? KW'(MAX_CREDIT)
                                                          : KW'(w_data.credit);
    assign w_ready = (state_reg == ST_IDLE) && out_free;
    assign take = w_valid && w_ready;
    assign do_read = (state_reg == ST_READ);
    assign emit = (state_reg == ST_EMIT) && out_free;
    assign rd_base = CW'(wp_reg[first_q]);
    assign rd_idx = (rd_base >= fill_reg[first_q]) ? RW'(rd_base - fill_reg[first_q])
                  : RW'(rd_base + CW'(RING_DEPTH) - fill_reg[first_q]);
    assign last_pkt = (left_reg == KW'(1)) || ($countones(nonempty) == 1 &&
                      fill_reg[q_reg] == CW'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && !is_enq && credit_sat != '0 && any_ne)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = last_pkt ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            left_reg <= '0;
            q_reg <= '0;
            for (int i = 0; i < NUM_PRIORITIES; i++)
            begin
                wp_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if ((take && is_enq && (w_data.bad || enq_full)) || emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (o_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (take && is_enq && !w_data.bad && !enq_full)
            begin
                wp_reg[wq] <= (wp_reg[wq] == RW'(RING_DEPTH - 1)) ? '0 : wp_reg[wq] + 1'b1;
                fill_reg[wq] <= fill_reg[wq] + 1'b1;
            end
            if (take && !is_enq)
            begin
                left_reg <= credit_sat;
            end
            if (do_read)
            begin
                q_reg <= first_q;
            end
            if (emit)
            begin
                left_reg <= left_reg - 1'b1;
                fill_reg[q_reg] <= fill_reg[q_reg] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && is_enq && !w_data.bad && !enq_full)
        begin
            store_reg[{wq, RW'(wp_reg[wq])}] <= w_data.handle;
        end
        if (do_read)
        begin
            rdata_reg <= store_reg[{first_q, rd_idx}];
        end
        if (take && is_enq)
        begin
            ok_reg <= w_data.bad ? KIND_BAD : KIND_FULL;
            oh_reg <= w_data.handle;
            op_reg <= PRIO_W'(w_data.prio);
            ol_reg <= 1'b1;
        end
        if (emit)
        begin
            ok_reg <= KIND_FWD;
            oh_reg <= rdata_reg;
            op_reg <= PRIO_W'(q_reg);
            ol_reg <= last_pkt;
        end
    end

    assign o_valid = ov_reg;
    assign o_kind = ok_reg;
    assign o_handle = oh_reg;
    assign o_prio = op_reg;
    assign o_last = ol_reg;
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the header priority classify queue with a built-in queue model.
`timescale 1ns / 100ps

module testbench;
    import hpcq_pkg::*;

    typedef struct {
        cmd_t         cmd;
        logic [15:0]  handle;
        logic [383:0] hdr;
        logic [5:0]   credit;
    } pkt_cmd_t;

    typedef struct {
        kind_t       kind;
        logic [15:0] handle;
        logic [3:0]  prio;
        logic        last;
    } outcome_t;

    localparam int RING_LIMIT = 64;
    localparam int CREDIT_LIMIT = 32;
    localparam int QUIET_LIMIT = 3000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [407:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [3:0]   cfg_data;

    pkt_cmd_t    pending_cmds[$];
    pkt_cmd_t    in_flight;
    bit          holding;
    outcome_t    expected_out[$];
    logic [15:0] prio_ring[16][$];
    logic [3:0]  high_reg;
    logic [3:0]  low_reg;
    bit          steady;
    bit          hold_request;
    bit          hold_taken;
    int          hold_count;
    int          quiet_cycles;
    int          mismatches;

    header_priority_classify_queue_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] frame_byte(input logic [383:0] h, input int k);
        return h[383 - 8 * k -: 8];
    endfunction

    function automatic logic [15:0] frame_half(input logic [383:0] h, input int k);
        return {frame_byte(h, k), frame_byte(h, k + 1)};
    endfunction

    function automatic bit ip_queue(input logic [383:0] h, input int ip, input int l2,
                                    output int prio);
        int          dscp;
        logic [7:0]  vihl;
        logic [15:0] sport;
        logic [15:0] dport;
        dscp = frame_byte(h, ip + 1) >> 2;
        vihl = frame_byte(h, ip);
        sport = frame_half(h, ip + 20);
        dport = frame_half(h, ip + 22);
        prio = l2;
        if (vihl[7:4] != IP_VERSION_OK)
            return 0;
        if (dscp != 0)
            prio = (16 - dscp - 1 < 0) ? 0 : 16 - dscp - 1;
        if (frame_byte(h, ip + 9) == IP_PROTO_UDP &&
            ((sport == PORT_SERVER && dport == PORT_CLIENT) ||
             (sport == PORT_CLIENT && dport == PORT_SERVER)))
            prio = high_reg;
        return 1;
    endfunction

    function automatic bit classify_frame(input logic [383:0] h, output int prio);
        logic [15:0] etype;
        int          outer;
        etype = frame_half(h, 12);
        prio = 0;
        if (etype == ETH_QINQ)
        begin
            if (frame_half(h, 16) != ETH_VLAN)
                return 0;
            outer = frame_half(h, 14) >> 13;
            return ip_queue(h, 22, outer != 0 ? outer : frame_half(h, 18) >> 13, prio);
        end
        if (etype == ETH_IPV4)
            return ip_queue(h, 14, low_reg, prio);
        return 1;
    endfunction

    task automatic predict_outcomes(input pkt_cmd_t c);
        int prio;
        int limit;
        int n;
        if (c.cmd == CMD_ENQ)
        begin
            if (!classify_frame(c.hdr, prio))
                expected_out.push_back('{KIND_BAD, c.handle, 4'd0, 1'b1});
            else if (prio_ring[prio].size() >= RING_LIMIT)
                expected_out.push_back('{KIND_FULL, c.handle, prio[3:0], 1'b1});
            else
                prio_ring[prio].push_back(c.handle);
        end
        else
        begin
            limit = (c.credit > CREDIT_LIMIT) ? CREDIT_LIMIT : c.credit;
            n = 0;
            for (int q = 0; q < 16; q++)
                while (prio_ring[q].size() != 0 && n < limit)
                begin
                    expected_out.push_back('{KIND_FWD, prio_ring[q].pop_front(), q[3:0], 1'b0});
                    n++;
                end
            if (n > 0)
                expected_out[expected_out.size() - 1].last = 1'b1;
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("Mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic logic [407:0] pack_cmd(input pkt_cmd_t c);
        logic [407:0] d;
        d = '0;
        d[15:0] = c.handle;
        for (int i = 0; i < 6; i++)
            d[16 + 64 * i +: 64] = c.hdr[383 - 64 * i -: 64];
        d[405:400] = c.credit;
        return d;
    endfunction

    function automatic logic [383:0] set_ip(input logic [383:0] h, input int ip);
        h[383 - 8 * ip -: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom) : IP_VERSION_OK;
        if ($urandom_range(0, 1) == 0)
            h[383 - 8 * (ip + 1) -: 6] = 6'd0;
        if ($urandom_range(0, 1) == 0)
        begin
            h[383 - 8 * (ip + 9) -: 8] = IP_PROTO_UDP;
            if ($urandom_range(0, 2) != 0)
            begin
                h[383 - 8 * (ip + 20) -: 16] = $urandom_range(0, 1) ? PORT_SERVER : PORT_CLIENT;
                h[383 - 8 * (ip + 22) -: 16] =
                    (h[383 - 8 * (ip + 20) -: 16] == PORT_SERVER) ? PORT_CLIENT : PORT_SERVER;
            end
        end
        return h;
    endfunction

    function automatic logic [383:0] make_header(input int flavor);
        logic [383:0] h;
        for (int i = 0; i < 12; i++)
            h[32 * i +: 32] = $urandom;
        if (flavor < 0)
            flavor = $urandom_range(0, 7);
        if (flavor >= 1 && flavor <= 4)
        begin
            h[383 - 96 -: 16] = ETH_IPV4;
            h = set_ip(h, 14);
        end
        else if (flavor >= 5)
        begin
            h[383 - 96 -: 16] = ETH_QINQ;
            if ($urandom_range(0, 9) != 0)
                h[383 - 128 -: 16] = ETH_VLAN;
            if ($urandom_range(0, 2) == 0)
                h[383 - 112 -: 3] = 3'd0;
            h = set_ip(h, 22);
        end
        return h;
    endfunction

    function automatic pkt_cmd_t enq_cmd(input logic [383:0] h);
        return '{CMD_ENQ, 16'($urandom), h, 6'($urandom)};
    endfunction

    function automatic pkt_cmd_t deq_cmd(input logic [5:0] credit);
        pkt_cmd_t c;
        c = '{CMD_DEQ, 16'($urandom), make_header(0), credit};
        return c;
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            if ($urandom_range(0, 3) == 0)
                pending_cmds.push_back(deq_cmd($urandom_range(0, 4) == 0 ?
                                               6'($urandom) : 6'($urandom_range(1, 32))));
            else
                pending_cmds.push_back(enq_cmd(make_header(-1)));
    endtask

    task automatic drain;
        while (pending_cmds.size() != 0 || holding || expected_out.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] index, input logic [3:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == CFG_DHCP_QUEUE)
            high_reg = value;
        else
            low_reg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (!holding && pending_cmds.size() != 0 && rst_n &&
            (steady || $urandom_range(0, 99) >= 30))
        begin
            in_flight = pending_cmds.pop_front();
            s_axis_tdata = pack_cmd(in_flight);
            s_axis_tuser = in_flight.cmd;
            s_axis_tvalid = 1'b1;
            holding = 1;
        end
        else if (!holding)
            s_axis_tvalid = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_taken = 1;
            hold_count = 400;
        end
        if (hold_count > 0)
        begin
            hold_count--;
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = steady || $urandom_range(0, 99) >= 30;
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (s_axis_tvalid && s_axis_tready)
        begin
            predict_outcomes(in_flight);
            holding = 0;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_out.size() == 0)
                report("unexpected result handle", m_axis_tdata[15:0], 32'h0);
            else
            begin
                want = expected_out.pop_front();
                if (m_axis_tuser != want.kind)
                    report("result_kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[15:0] != want.handle)
                    report("out_handle", m_axis_tdata[15:0], want.handle);
                if (m_axis_tdata[19:16] != want.prio)
                    report("out_priority", m_axis_tdata[19:16], want.prio);
                if (m_axis_tlast != want.last)
                    report("last_of_run", m_axis_tlast, want.last);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (++quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [383:0] h;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DHCP_QUEUE;
        cfg_data = 4'd0;
        high_reg = 4'd0;
        low_reg = 4'd15;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames: field extremes, tagging and IP corner cases, credit extremes.
        pending_cmds.push_back(deq_cmd(6'd5));
        pending_cmds.push_back('{CMD_ENQ, 16'h0000, '0, 6'd0});
        pending_cmds.push_back('{CMD_ENQ, 16'hFFFF, '1, 6'h3F});
        h = '0; h[287:272] = ETH_IPV4; h[271:264] = 8'h45; h[263:256] = 8'hFC;
        pending_cmds.push_back(enq_cmd(h));
        h[263:256] = 8'h04;
        pending_cmds.push_back(enq_cmd(h));
        h[263:256] = 8'h00;
        pending_cmds.push_back(enq_cmd(h));
        h[271:264] = 8'h65;
        pending_cmds.push_back(enq_cmd(h));
        h[271:264] = 8'h45; h[199:192] = IP_PROTO_UDP;
        h[111:96] = PORT_SERVER; h[95:80] = PORT_CLIENT;
        pending_cmds.push_back(enq_cmd(h));
        h[111:96] = PORT_CLIENT; h[95:80] = PORT_SERVER;
        pending_cmds.push_back(enq_cmd(h));
        h[95:80] = PORT_CLIENT;
        pending_cmds.push_back(enq_cmd(h));
        h = '0; h[287:272] = ETH_QINQ; h[271:256] = 16'hE000; h[255:240] = ETH_VLAN;
        h[239:224] = 16'hA000; h[207:200] = 8'h45;
        pending_cmds.push_back(enq_cmd(h));
        h[271:256] = 16'h1FFF;
        pending_cmds.push_back(enq_cmd(h));
        h[207:200] = 8'h35;
        pending_cmds.push_back(enq_cmd(h));
        h[207:200] = 8'h45; h[255:240] = 16'h8101;
        pending_cmds.push_back(enq_cmd(h));
        pending_cmds.push_back(deq_cmd(6'd0));
        pending_cmds.push_back(deq_cmd(6'd1));
        pending_cmds.push_back(deq_cmd(6'h3F));
        pending_cmds.push_back(deq_cmd(6'd32));
        drain();

        write_reg(CFG_DHCP_QUEUE, 4'd15);
        write_reg(CFG_DEFAULT_QUEUE, 4'd0);
        queue_random(20);
        drain();

        // Overflow one ring, then let the results back up behind a stalled receiver.
        write_reg(CFG_DHCP_QUEUE, 4'($urandom_range(1, 14)));
        write_reg(CFG_DEFAULT_QUEUE, 4'($urandom_range(1, 14)));
        steady = 1;
        for (int i = 0; i < 66; i++)
            pending_cmds.push_back(enq_cmd(make_header(0) & ~(384'hFFFF << 272)));
        hold_request = 1;
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back(deq_cmd(6'd32));
        drain();
        steady = 0;

        write_reg(CFG_DHCP_QUEUE, 4'd0);
        write_reg(CFG_DEFAULT_QUEUE, 4'd15);
        queue_random(14);
        pending_cmds.push_back(deq_cmd(6'd32));
        pending_cmds.push_back(deq_cmd(6'd32));
        drain();
        repeat (30) @(posedge clk);

        if (mismatches == 0 && expected_out.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/hpcq_pkg.sv
design/hpcq_front.sv
design/hpcq_fifo.sv
design/hpcq_back.sv
design/header_priority_classify_queue_core.sv
tb/sv/testbench.sv
